// ===== rtl/teq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event queue package
// Shared codes, widths and command types for the timed event queue.
// ----------------------------------------------------------------------------
package teq_pkg;

   // Fixed widths of the transaction fields.
   localparam int TIME_W   = 62;
   localparam int DELTA_W  = 32;
   localparam int PTAG_W   = 8;
   localparam int STATUS_W = 2;

   // Request codes.
   localparam logic [1:0] REQ_TICK      = 2'd0;
   localparam logic [1:0] REQ_SCHEDULE  = 2'd1;
   localparam logic [1:0] REQ_HELD      = 2'd2;
   localparam logic [1:0] REQ_DESCHED   = 2'd3;

   // Status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   // Command to every cell of the sorted queue.
   typedef enum logic [1:0] {
      SLOT_HOLD,
      SLOT_INSERT,
      SLOT_REMOVE,
      SLOT_POP
   } slot_op_type;

   // Command to every cell of the held FIFO.
   typedef enum logic [1:0] {
      HELD_HOLD,
      HELD_PUSH,
      HELD_POP
   } held_op_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_MERGE = 3'b010,
      ST_ISSUE = 3'b100
   } state_type;

endpackage

// ===== rtl/teq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event queue channels
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface teq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] delta;
   logic [7:0]  event_tag;

   modport source (output valid, req_type, delta, event_tag, input ready);
   modport sink   (input valid, req_type, delta, event_tag, output ready);
endinterface

interface teq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        fired;
   logic [7:0]  fired_tag;
   logic        last_result;
   logic [61:0] time_now;

   modport source (output valid, status, fired, fired_tag, last_result, time_now,
                   input ready);
   modport sink   (input valid, status, fired, fired_tag, last_result, time_now,
                   output ready);
endinterface

// ===== rtl/teq_slot_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event queue slot cell
// One entry of the sorted queue; shifts toward either neighbor on command.
// ----------------------------------------------------------------------------
module teq_slot_cell #(
   parameter int TAG_WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  teq_pkg::slot_op_type     op,
   input  logic [teq_pkg::TIME_W-1:0] op_time,
   input  logic [TAG_WIDTH-1:0]     op_tag,
   input  logic [teq_pkg::TIME_W-1:0] now,
   input  logic                     left_valid,
   input  logic [teq_pkg::TIME_W-1:0] left_time,
   input  logic [TAG_WIDTH-1:0]     left_tag,
   input  logic                     left_le,
   input  logic                     right_valid,
   input  logic [teq_pkg::TIME_W-1:0] right_time,
   input  logic [TAG_WIDTH-1:0]     right_tag,
   input  logic                     prev_hit,
   output logic                     valid,
   output logic [teq_pkg::TIME_W-1:0] slot_time,
   output logic [TAG_WIDTH-1:0]     slot_tag,
   output logic                     le_out,
   output logic                     hit_out,
   output logic                     due_out
);
   import teq_pkg::*;

   logic                 valid_ff, valid_in;
   logic [TIME_W-1:0]    time_ff, time_in;
   logic [TAG_WIDTH-1:0] tag_ff, tag_in;

   // Local compares handed along the chain.
   assign le_out  = valid_ff && (time_ff <= op_time);
   assign hit_out = prev_hit || (valid_ff && (tag_ff == op_tag));
   assign due_out = valid_ff && (time_ff <= now);

   // Next entry: keep, take the new entry, or take a neighbor's.
   always_comb begin
      valid_in = valid_ff;
      time_in  = time_ff;
      tag_in   = tag_ff;
      unique case (op)
         SLOT_INSERT: begin
            if (!le_out) begin
               if (left_le) begin
                  valid_in = 1'b1;
                  time_in  = op_time;
                  tag_in   = op_tag;
               end else begin
                  valid_in = left_valid;
                  time_in  = left_time;
                  tag_in   = left_tag;
               end
            end
         end
         SLOT_REMOVE: begin
            if (hit_out) begin
               valid_in = right_valid;
               time_in  = right_time;
               tag_in   = right_tag;
            end
         end
         SLOT_POP: begin
            valid_in = right_valid;
            time_in  = right_time;
            tag_in   = right_tag;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      time_ff <= time_in;
      tag_ff  <= tag_in;
   end

   assign valid     = valid_ff;
   assign slot_time = time_ff;
   assign slot_tag  = tag_ff;

endmodule

// ===== rtl/teq_held_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event queue held cell
// One entry of the held FIFO; fills at the tail and shifts toward the head.
// ----------------------------------------------------------------------------
module teq_held_cell #(
   parameter int TAG_WIDTH = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  teq_pkg::held_op_type        op,
   input  logic [teq_pkg::DELTA_W-1:0] new_delta,
   input  logic [TAG_WIDTH-1:0]        new_tag,
   input  logic                        left_valid,
   input  logic                        right_valid,
   input  logic [teq_pkg::DELTA_W-1:0] right_delta,
   input  logic [TAG_WIDTH-1:0]        right_tag,
   output logic                        valid,
   output logic [teq_pkg::DELTA_W-1:0] held_delta,
   output logic [TAG_WIDTH-1:0]        held_tag
);
   import teq_pkg::*;

   logic                 valid_ff, valid_in;
   logic [DELTA_W-1:0]   delta_ff, delta_in;
   logic [TAG_WIDTH-1:0] tag_ff, tag_in;

   // The first empty cell takes a push; every cell takes its right neighbor on pop.
   always_comb begin
      valid_in = valid_ff;
      delta_in = delta_ff;
      tag_in   = tag_ff;
      unique case (op)
         HELD_PUSH: begin
            if (!valid_ff && left_valid) begin
               valid_in = 1'b1;
               delta_in = new_delta;
               tag_in   = new_tag;
            end
         end
         HELD_POP: begin
            valid_in = right_valid;
            delta_in = right_delta;
            tag_in   = right_tag;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      delta_ff <= delta_in;
      tag_ff   <= tag_in;
   end

   assign valid      = valid_ff;
   assign held_delta = delta_ff;
   assign held_tag   = tag_ff;

endmodule

// ===== rtl/timed_event_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event queue
// Absolute time counter with a time-ordered queue of tagged events.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req_chan (tick, schedule, held schedule,
// deschedule); results leave on rsp_chan, each with a last_result mark.
// Schedule, held schedule and deschedule each give one transaction,
// registered, in the cycle after acceptance. The sorted queue is a row of
// cells that insert, remove or pop by taking a neighbor's entry.
// A tick runs through acceptance, a merge phase of one sorted insert per
// held entry that ends when it finds the held FIFO empty, and an issue
// phase that issues the due events, one per cycle while the output register
// is free, or one result when none is due. The next request is taken once
// the tick has delivered its last transaction into the output register.
// Reset clears the time counter and the valid bits of both cell rows; no
// clearing pass is needed. When the receiver stalls, the output register
// holds its transaction and the block waits, losing nothing.
// ----------------------------------------------------------------------------
module timed_event_queue_top #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TAG_WIDTH   = 8
) (
   input  logic       clock,
   input  logic       reset,
   teq_req_if.sink    req_chan,
   teq_rsp_if.source  rsp_chan
);
   import teq_pkg::*;

   localparam int QD = QUEUE_DEPTH;

   state_type            state_ff, state_in;
   logic [TIME_W-1:0]    time_ff, time_in;
   logic                 drop_ff, drop_in;

   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff, out_status;
   logic                 rsp_fired_ff, out_fired;
   logic [PTAG_W-1:0]    rsp_tag_ff, out_tag;
   logic                 rsp_last_ff, out_last;
   logic [TIME_W-1:0]    rsp_time_ff;
   logic                 out_load, out_free;

   slot_op_type          slot_op;
   held_op_type          held_op;
   logic [TAG_WIDTH-1:0] op_tag, req_tag;
   logic [DELTA_W-1:0]   op_delta;
   logic [TIME_W:0]      ins_sum;
   logic [TIME_W-1:0]    ins_time;

   logic [QD-1:0]        s_valid, s_le, s_hit, s_due;
   logic [TIME_W-1:0]    s_time [QD];
   logic [TAG_WIDTH-1:0] s_tag [QD];

   logic [QD-1:0]        h_valid;
   logic [DELTA_W-1:0]   h_delta [QD];
   logic [TAG_WIDTH-1:0] h_tag [QD];

   assign req_tag  = TAG_WIDTH'(req_chan.event_tag);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Event time, saturated at the top of the time range.
   assign ins_sum  = {1'b0, time_ff} + (TIME_W + 1)'(op_delta);
   assign ins_time = ins_sum[TIME_W] ? {TIME_W{1'b1}} : ins_sum[TIME_W-1:0];

   // Sorted queue cells.
   for (genvar i = 0; i < QD; i++) begin : g_slot
      logic                 lv, lle, rv, ph;
      logic [TIME_W-1:0]    lt, rt;
      logic [TAG_WIDTH-1:0] ltag, rtag;
      if (i == 0) begin : g_first
         assign lv = 1'b0;
         assign lle = 1'b1;
         assign lt = '0;
         assign ltag = '0;
         assign ph = 1'b0;
      end else begin : g_mid
         assign lv = s_valid[i-1];
         assign lle = s_le[i-1];
         assign lt = s_time[i-1];
         assign ltag = s_tag[i-1];
         assign ph = s_hit[i-1];
      end
      if (i == QD - 1) begin : g_last
         assign rv = 1'b0;
         assign rt = '0;
         assign rtag = '0;
      end else begin : g_inner
         assign rv = s_valid[i+1];
         assign rt = s_time[i+1];
         assign rtag = s_tag[i+1];
      end
      teq_slot_cell #(.TAG_WIDTH(TAG_WIDTH)) u_cell (
         .clock(clock), .reset(reset), .op(slot_op), .op_time(ins_time),
         .op_tag(op_tag), .now(time_ff),
         .left_valid(lv), .left_time(lt), .left_tag(ltag), .left_le(lle),
         .right_valid(rv), .right_time(rt), .right_tag(rtag), .prev_hit(ph),
         .valid(s_valid[i]), .slot_time(s_time[i]), .slot_tag(s_tag[i]),
         .le_out(s_le[i]), .hit_out(s_hit[i]), .due_out(s_due[i])
      );
   end

   // Held FIFO cells.
   for (genvar i = 0; i < QD; i++) begin : g_held
      logic                 lv, rv;
      logic [DELTA_W-1:0]   rd;
      logic [TAG_WIDTH-1:0] rtag;
      if (i == 0) begin : g_first
         assign lv = 1'b1;
      end else begin : g_mid
         assign lv = h_valid[i-1];
      end
      if (i == QD - 1) begin : g_last
         assign rv = 1'b0;
         assign rd = '0;
         assign rtag = '0;
      end else begin : g_inner
         assign rv = h_valid[i+1];
         assign rd = h_delta[i+1];
         assign rtag = h_tag[i+1];
      end
      teq_held_cell #(.TAG_WIDTH(TAG_WIDTH)) u_cell (
         .clock(clock), .reset(reset), .op(held_op),
         .new_delta(req_chan.delta), .new_tag(req_tag),
         .left_valid(lv), .right_valid(rv), .right_delta(rd), .right_tag(rtag),
         .valid(h_valid[i]), .held_delta(h_delta[i]), .held_tag(h_tag[i])
      );
   end

   // Request sequencer.
   always_comb begin
      state_in   = state_ff;
      time_in    = time_ff;
      drop_in    = drop_ff;
      slot_op    = SLOT_HOLD;
      held_op    = HELD_HOLD;
      op_tag     = req_tag;
      op_delta   = req_chan.delta;
      out_load   = 1'b0;
      out_status = STATUS_OK;
      out_fired  = 1'b0;
      out_tag    = '0;
      out_last   = 1'b1;
      req_chan.ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = out_free;
            if (req_chan.valid && out_free) begin
               unique case (req_chan.req_type)
                  REQ_TICK: begin
                     drop_in  = 1'b0;
                     state_in = ST_MERGE;
                  end
                  REQ_SCHEDULE: begin
                     out_load = 1'b1;
                     if (s_valid[QD-1]) begin
                        out_status = STATUS_FULL;
                     end else begin
                        slot_op = SLOT_INSERT;
                     end
                  end
                  REQ_HELD: begin
                     out_load = 1'b1;
                     if (h_valid[QD-1]) begin
                        out_status = STATUS_FULL;
                     end else begin
                        held_op = HELD_PUSH;
                     end
                  end
                  default: begin
                     out_load = 1'b1;
                     if (s_hit[QD-1]) begin
                        slot_op = SLOT_REMOVE;
                     end else begin
                        out_status = STATUS_NOT_FOUND;
                     end
                  end
               endcase
            end
         end
         ST_MERGE: begin
            // Merge the oldest held entry, one sorted insert per cycle.
            op_tag   = h_tag[0];
            op_delta = h_delta[0];
            if (h_valid[0]) begin
               held_op = HELD_POP;
               if (s_valid[QD-1]) begin
                  drop_in = 1'b1;
               end else begin
                  slot_op = SLOT_INSERT;
               end
            end else begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            // Issue due events from the head, one per cycle while the output is free.
            if (out_free) begin
               out_load   = 1'b1;
               out_status = drop_ff ? STATUS_FULL : STATUS_OK;
               if (s_due[0]) begin
                  out_fired = 1'b1;
                  out_tag   = PTAG_W'(s_tag[0]);
                  out_last  = !s_due[1];
                  slot_op   = SLOT_POP;
               end
               if (!s_due[0] || !s_due[1]) begin
                  time_in  = time_ff + 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         time_ff      <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         time_ff  <= time_in;
         drop_ff  <= drop_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff <= out_status;
         rsp_fired_ff  <= out_fired;
         rsp_tag_ff    <= out_tag;
         rsp_last_ff   <= out_last;
         rsp_time_ff   <= time_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.fired       = rsp_fired_ff;
   assign rsp_chan.fired_tag   = rsp_tag_ff;
   assign rsp_chan.last_result = rsp_last_ff;
   assign rsp_chan.time_now    = rsp_time_ff;

   // Occupied queue cells form one unbroken run from the head.
   a_slot_packed: assert property (@(posedge clock) disable iff (reset)
      ((s_valid >> 1) & ~s_valid) == '0)
      else $error("Sorted queue has a gap.");

   // Occupied held cells form one unbroken run from the head.
   a_held_packed: assert property (@(posedge clock) disable iff (reset)
      ((h_valid >> 1) & ~h_valid) == '0)
      else $error("Held FIFO has a gap.");

   // An accepted tick always starts with the merge phase.
   a_tick_merge: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.req_type == REQ_TICK)
      |=> state_ff == ST_MERGE)
      else $error("Tick did not enter merge.");

   // The time counter only moves when a tick finishes.
   a_time_step: assert property (@(posedge clock) disable iff (reset)
      (time_ff != $past(time_ff)) |-> ($past(state_ff) == ST_ISSUE))
      else $error("Time advanced outside a tick.");

endmodule

// ===== dv/timed_event_queue_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event queue testbench
// Drives ticks, schedules, held schedules and deschedules into the timed
// event queue, predicts every response with a behavioral copy of the queue,
// and checks each response transaction field by field in order.
// ----------------------------------------------------------------------------
module timed_event_queue_top_tb;
   import teq_pkg::*;

   localparam int DEPTH = 16;
   localparam logic [61:0] TIME_MAX = {62{1'b1}};

   typedef struct packed {
      logic [1:0]  status;
      logic        fired;
      logic [7:0]  fired_tag;
      logic        last_result;
      logic [61:0] time_now;
   } rsp_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   teq_req_if req_chan ();
   teq_rsp_if rsp_chan ();

   timed_event_queue_top #(.QUEUE_DEPTH(DEPTH), .TAG_WIDTH(8)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #5 clock = ~clock;

   // Predicted queue state.
   logic [61:0] now_time;
   logic [61:0] slot_time [DEPTH];
   logic [7:0]  slot_tag [DEPTH];
   int          queued_cnt;
   logic [31:0] park_delta [DEPTH];
   logic [7:0]  park_tag [DEPTH];
   int          park_cnt;

   rsp_item_type expected_rsps [$];
   int           error_count = 0;
   bit           idle_enable = 1'b1;

   // Sorted insert behind every entry that is not later; returns 0 when full.
   function automatic bit queue_insert(logic [31:0] delta, logic [7:0] tag);
      logic [62:0] sum;
      logic [61:0] at;
      int pos;
      if (queued_cnt >= DEPTH) return 1'b0;
      sum = {1'b0, now_time} + {31'd0, delta};
      at  = sum[62] ? TIME_MAX : sum[61:0];
      pos = 0;
      while (pos < queued_cnt && slot_time[pos] <= at) pos++;
      for (int i = queued_cnt; i > pos; i--) begin
         slot_time[i] = slot_time[i-1];
         slot_tag[i]  = slot_tag[i-1];
      end
      slot_time[pos] = at;
      slot_tag[pos]  = tag;
      queued_cnt++;
      return 1'b1;
   endfunction

   function automatic void queue_remove(int pos);
      for (int i = pos; i + 1 < queued_cnt; i++) begin
         slot_time[i] = slot_time[i+1];
         slot_tag[i]  = slot_tag[i+1];
      end
      queued_cnt--;
   endfunction

   function automatic void push_rsp(logic [1:0] st, logic fd, logic [7:0] tg, logic lst);
      rsp_item_type r;
      r.status = st; r.fired = fd; r.fired_tag = tg; r.last_result = lst;
      r.time_now = now_time;
      expected_rsps.push_back(r);
   endfunction

   // Works out the responses for one accepted request.
   function automatic void predict_request(logic [1:0] kind, logic [31:0] delta,
                                           logic [7:0] tag);
      logic [1:0] st;
      int n;
      bit found;
      st = STATUS_OK;
      n = 0;
      found = 1'b0;
      case (kind)
         REQ_SCHEDULE: begin
            push_rsp(queue_insert(delta, tag) ? STATUS_OK : STATUS_FULL, 1'b0, 8'd0, 1'b1);
         end
         REQ_HELD: begin
            if (park_cnt >= DEPTH) begin
               push_rsp(STATUS_FULL, 1'b0, 8'd0, 1'b1);
            end else begin
               park_delta[park_cnt] = delta;
               park_tag[park_cnt]   = tag;
               park_cnt++;
               push_rsp(STATUS_OK, 1'b0, 8'd0, 1'b1);
            end
         end
         REQ_DESCHED: begin
            for (int i = 0; i < queued_cnt && !found; i++) begin
               if (slot_tag[i] == tag) begin
                  queue_remove(i);
                  found = 1'b1;
               end
            end
            push_rsp(found ? STATUS_OK : STATUS_NOT_FOUND, 1'b0, 8'd0, 1'b1);
         end
         default: begin
            for (int i = 0; i < park_cnt; i++)
               if (!queue_insert(park_delta[i], park_tag[i])) st = STATUS_FULL;
            park_cnt = 0;
            while (queued_cnt > 0 && slot_time[0] <= now_time) begin
               push_rsp(st, 1'b1, slot_tag[0], 1'b0);
               queue_remove(0);
               n++;
            end
            if (n == 0) push_rsp(st, 1'b0, 8'd0, 1'b1);
            else expected_rsps[$].last_result = 1'b1;
            now_time = now_time + 62'd1;
         end
      endcase
   endfunction

   // Sends one request, with an occasional random idle burst before it. Valid stays high
   // into the next request unless an idle burst or a drain drops it.
   task automatic send_request(logic [1:0] kind, logic [31:0] delta, logic [7:0] tag);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.req_type  <= kind;
      req_chan.delta     <= delta;
      req_chan.event_tag <= tag;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_request(kind, delta, tag);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // Receiver stalls in random bursts.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   // Compares every response transaction with the oldest expectation.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response expected none actual st=%0d fired=%0d tag=%0d",
                     $time, rsp_chan.status, rsp_chan.fired, rsp_chan.fired_tag);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_chan.status !== want.status || rsp_chan.fired !== want.fired ||
                rsp_chan.fired_tag !== want.fired_tag ||
                rsp_chan.last_result !== want.last_result ||
                rsp_chan.time_now !== want.time_now) begin
               $display("%0t: mismatch expected st=%0d fired=%0d tag=%0d last=%0d time=%0d",
                        $time, want.status, want.fired, want.fired_tag, want.last_result,
                        want.time_now);
               $display("%0t:          actual   st=%0d fired=%0d tag=%0d last=%0d time=%0d",
                        $time, rsp_chan.status, rsp_chan.fired, rsp_chan.fired_tag,
                        rsp_chan.last_result, rsp_chan.time_now);
               error_count++;
            end
         end
      end
   end

   // Field extremes, every request kind and not-found cases.
   task automatic test_directed();
      send_request(REQ_TICK, 32'd0, 8'd0);
      send_request(REQ_DESCHED, 32'd0, 8'hFF);
      send_request(REQ_SCHEDULE, 32'd0, 8'hFF);
      send_request(REQ_SCHEDULE, 32'd0, 8'h00);
      send_request(REQ_SCHEDULE, 32'hFFFF_FFFF, 8'hA5);
      send_request(REQ_HELD, 32'd1, 8'h5A);
      send_request(REQ_HELD, 32'd0, 8'h33);
      send_request(REQ_TICK, 32'hFFFF_FFFF, 8'hFF);
      send_request(REQ_TICK, 32'd0, 8'd0);
      send_request(REQ_DESCHED, 32'hFFFF_FFFF, 8'hA5);
      send_request(REQ_DESCHED, 32'd0, 8'hA5);
      send_request(REQ_TICK, 32'd0, 8'd0);
   endtask

   // Fills the queue and the held FIFO past capacity, then merges into a full queue.
   task automatic test_full();
      wait_drained();
      for (int i = 0; i < DEPTH + 2; i++)
         send_request(REQ_SCHEDULE, $urandom_range(0, 3), 8'(i));
      for (int i = 0; i < DEPTH + 1; i++)
         send_request(REQ_HELD, $urandom_range(0, 2), 8'(i + 100));
      for (int i = 0; i < 6; i++) send_request(REQ_TICK, 32'd0, 8'd0);
   endtask

   // Random traffic of all four request kinds, mostly small deltas, small tags if small_tags.
   task automatic test_random(int count, bit small_tags);
      logic [1:0] kind;
      logic [31:0] delta;
      for (int i = 0; i < count; i++) begin
         kind  = 2'($urandom_range(0, 3));
         delta = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 5);
         if (i == count / 2) wait_drained();
         send_request(kind, delta, small_tags ? 8'($urandom_range(0, 7)) : 8'($urandom));
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.req_type = REQ_TICK;
      req_chan.delta = '0;
      req_chan.event_tag = '0;
      now_time = '0;
      queued_cnt = 0;
      park_cnt = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full();
      test_random(40, 1'b1);
      test_random(20, 1'b0);
      idle_enable = 1'b0;
      test_random(20, 1'b1);
      req_chan.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   // Watchdog on the whole run.
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
